// ===== rtl/mpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpw_pkg
// shared types, register indexes, reset values and status codes of the
// motion progress watchdog
// ----------------------------------------------------------------------------
package mpw_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_ENABLE  = 3'd4;

    localparam logic [15:0] RADIUS_RST       = 16'd500;
    localparam logic [31:0] RADIUS_SQ_RST    = 32'(RADIUS_RST) * 32'(RADIUS_RST);
    localparam logic [23:0] MOVE_TIMEOUT_RST = 24'd10000;
    localparam logic [23:0] TURN_TIMEOUT_RST = 24'd30000;
    localparam logic [15:0] YAW_THRESH_RST   = 16'd313;
    localparam logic        TURN_ENABLE_RST  = 1'b1;

    localparam logic [15:0] YAW_FLOOR = 16'd10;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [2:0] ST_BASELINE    = 3'd0;
    localparam logic [2:0] ST_TRANSLATION = 3'd1;
    localparam logic [2:0] ST_ROTATION    = 3'd2;
    localparam logic [2:0] ST_WAITING     = 3'd3;
    localparam logic [2:0] ST_STALLED     = 3'd4;
    localparam logic [2:0] ST_CLEARED     = 3'd5;

    typedef struct packed {
        logic [31:0] radius_sq;
        logic [23:0] move_timeout_ms;
        logic [23:0] turn_timeout_ms;
        logic [15:0] yaw_threshold;
        logic        turn_check_enable;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [15:0] yaw;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic        progress_ok;
        logic [2:0]  status_code;
        logic        rotation_flag;
        logic [23:0] timeout_used_ms;
    } result_t;

endpackage

// ===== rtl/mpw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpw_cfg_regs
// configuration register file; the radius is kept as its square
// ----------------------------------------------------------------------------
module mpw_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mpw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output mpw_pkg::cfg_t                   cfg
);
    import mpw_pkg::*;

    logic [31:0] radius_sq_reg;
    logic [23:0] move_timeout_reg;
    logic [23:0] turn_timeout_reg;
    logic [15:0] yaw_thresh_reg;
    logic        turn_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg    <= RADIUS_SQ_RST;
            move_timeout_reg <= MOVE_TIMEOUT_RST;
            turn_timeout_reg <= TURN_TIMEOUT_RST;
            yaw_thresh_reg   <= YAW_THRESH_RST;
            turn_enable_reg  <= TURN_ENABLE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RADIUS:       radius_sq_reg    <= 32'(cfg_wdata[15:0]) *
                                                      32'(cfg_wdata[15:0]);
                REG_MOVE_TIMEOUT: move_timeout_reg <= cfg_wdata[23:0];
                REG_TURN_TIMEOUT: turn_timeout_reg <= cfg_wdata[23:0];
                REG_YAW_THRESH:   yaw_thresh_reg   <= cfg_wdata[15:0];
                REG_TURN_ENABLE:  turn_enable_reg  <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign cfg.radius_sq         = radius_sq_reg;
    assign cfg.move_timeout_ms   = move_timeout_reg;
    assign cfg.turn_timeout_ms   = turn_timeout_reg;
    assign cfg.yaw_threshold     = yaw_thresh_reg;
    assign cfg.turn_check_enable = turn_enable_reg;

endmodule

// ===== rtl/mpw_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpw_core
// baseline and rotation state with the single-pass progress decision
// ----------------------------------------------------------------------------
module mpw_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mpw_pkg::item_t    item,
    input  mpw_pkg::cfg_t     cfg,
    output mpw_pkg::result_t  result
);
    import mpw_pkg::*;

    logic        base_valid_reg, base_valid_next;
    logic [23:0] base_x_reg, base_x_next;
    logic [23:0] base_y_reg, base_y_next;
    logic [15:0] prev_yaw_reg, prev_yaw_next;
    logic        turning_reg, turning_next;
    logic [31:0] base_time_reg, base_time_next;
    logic [31:0] turn_time_reg, turn_time_next;

    logic signed [24:0] dx, dy;
    logic [24:0] adx, ady;
    logic [49:0] dx_sq, dy_sq;
    logic [50:0] dist_sq;
    logic        moved;
    logic [15:0] yaw_diff, yaw_mag, yaw_thr;
    logic        rotated;
    logic [31:0] stamp_ms, elapsed;
    logic [23:0] tmo_sel;

    // squared distance from baseline
    assign dx = $signed({item.pos_x[23], item.pos_x}) - $signed({base_x_reg[23], base_x_reg});
    assign dy = $signed({item.pos_y[23], item.pos_y}) - $signed({base_y_reg[23], base_y_reg});
    assign adx = dx[24] ? (~dx + 25'd1) : dx;
    assign ady = dy[24] ? (~dy + 25'd1) : dy;
    assign dx_sq = 50'(adx) * 50'(adx);
    assign dy_sq = 50'(ady) * 50'(ady);
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign moved = dist_sq > {19'd0, cfg.radius_sq};

    // wrapped yaw change against floored threshold
    assign yaw_diff = item.yaw - prev_yaw_reg;
    assign yaw_mag  = yaw_diff[15] ? (~yaw_diff + 16'd1) : yaw_diff;
    assign yaw_thr  = (cfg.yaw_threshold > YAW_FLOOR) ? cfg.yaw_threshold : YAW_FLOOR;
    assign rotated  = cfg.turn_check_enable && (yaw_mag >= yaw_thr);

    // elapsed time from the active stamp
    assign stamp_ms = turning_reg ? turn_time_reg : base_time_reg;
    assign elapsed  = item.now_ms - stamp_ms;
    assign tmo_sel  = turning_reg ? cfg.turn_timeout_ms : cfg.move_timeout_ms;

    always_comb
    begin
        base_valid_next = base_valid_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        prev_yaw_next   = prev_yaw_reg;
        turning_next    = turning_reg;
        base_time_next  = base_time_reg;
        turn_time_next  = turn_time_reg;
        result.progress_ok     = 1'b1;
        result.status_code     = ST_CLEARED;
        result.timeout_used_ms = 24'd0;

        if (item.opcode == OP_CLEAR)
        begin
            base_valid_next    = 1'b0;
            turning_next       = 1'b0;
            turn_time_next     = 32'd0;
            result.status_code = ST_CLEARED;
        end
        else if (!base_valid_reg || moved)
        begin
            base_valid_next    = 1'b1;
            base_x_next        = item.pos_x;
            base_y_next        = item.pos_y;
            base_time_next     = item.now_ms;
            prev_yaw_next      = item.yaw;
            turning_next       = 1'b0;
            result.status_code = base_valid_reg ? ST_TRANSLATION : ST_BASELINE;
        end
        else
        begin
            if (cfg.turn_check_enable)
            begin
                prev_yaw_next = item.yaw;
            end
            if (rotated)
            begin
                turning_next           = 1'b1;
                turn_time_next         = item.now_ms;
                result.status_code     = ST_ROTATION;
                result.timeout_used_ms = cfg.turn_timeout_ms;
            end
            else
            begin
                result.timeout_used_ms = tmo_sel;
                result.progress_ok     = elapsed <= {8'd0, tmo_sel};
                result.status_code     = result.progress_ok ? ST_WAITING : ST_STALLED;
            end
        end
        result.rotation_flag = turning_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_valid_reg <= 1'b0;
            base_x_reg     <= 24'd0;
            base_y_reg     <= 24'd0;
            prev_yaw_reg   <= 16'd0;
            turning_reg    <= 1'b0;
            base_time_reg  <= 32'd0;
            turn_time_reg  <= 32'd0;
        end
        else if (fire)
        begin
            base_valid_reg <= base_valid_next;
            base_x_reg     <= base_x_next;
            base_y_reg     <= base_y_next;
            prev_yaw_reg   <= prev_yaw_next;
            turning_reg    <= turning_next;
            base_time_reg  <= base_time_next;
            turn_time_reg  <= turn_time_next;
        end
    end

endmodule

// ===== rtl/motion_progress_watchdog.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_progress_watchdog
// pose progress watchdog with baseline, translation and rotation tracking
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while out_ready holds and returns one
// result word per input word. A word is captured in an input register and
// decided once the result side can advance, when the result register loads
// and the baseline and rotation state update together. The state update
// through the distance squaring and compare sets the cycle time. While a
// result waits on out_ready one more word can be held in the input
// register. Configuration writes take effect at once and must be made
// while no word is in flight.
module motion_progress_watchdog (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mpw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic signed [23:0]              pos_x,
    input  logic signed [23:0]              pos_y,
    input  logic [15:0]                     yaw,
    input  logic [31:0]                     now_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            progress_ok,
    output logic [2:0]                      status_code,
    output logic                            rotation_flag,
    output logic [23:0]                     timeout_used_ms
);
    import mpw_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    fire;

    mpw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance  = !res_valid_reg || out_ready;
    assign fire     = item_valid_reg && advance;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.opcode <= opcode;
            item_reg.pos_x  <= pos_x;
            item_reg.pos_y  <= pos_y;
            item_reg.yaw    <= yaw;
            item_reg.now_ms <= now_ms;
        end
    end

    mpw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid       = res_valid_reg;
    assign progress_ok     = res_reg.progress_ok;
    assign status_code     = res_reg.status_code;
    assign rotation_flag   = res_reg.rotation_flag;
    assign timeout_used_ms = res_reg.timeout_used_ms;

    // a clear word always comes out as cleared
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.opcode == OP_CLEAR
        |=> res_valid_reg && res_reg.status_code == ST_CLEARED && !res_reg.rotation_flag)
        else $error("clear word did not give a cleared result");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // a rotation result carries the turn timeout and the active flag
    a_rotation_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status_code == ST_ROTATION
        |-> res_reg.rotation_flag && res_reg.progress_ok
            && res_reg.timeout_used_ms == cfg.turn_timeout_ms)
        else $error("rotation result inconsistent");

    // a pending input word moves on as soon as the result side frees up
    a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && advance |=> res_valid_reg)
        else $error("decided word lost before result register");

endmodule
